[rtl/core/utf16_to_utf8_encoder_macros.svh]
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder assertion macros
// Concurrent assertion helpers, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_ENCODER_MACROS_SVH
`define UTF16_TO_UTF8_ENCODER_MACROS_SVH

// same-cycle implication
`define U16U8_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u16u8 assertion failed");

// next-cycle implication
`define U16U8_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u16u8 assertion failed");

`endif

[rtl/core/u16u8_pkg.sv]
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and UTF-8 byte encoding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

   // surrogate ranges and UTF-8 limits
   localparam logic [15:0] HI_FIRST   = 16'hD800;
   localparam logic [15:0] HI_LAST    = 16'hDBFF;
   localparam logic [15:0] LO_FIRST   = 16'hDC00;
   localparam logic [15:0] LO_LAST    = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE  = 21'h10000;
   localparam logic [20:0] LIM_ONE    = 21'h80;
   localparam logic [20:0] LIM_TWO    = 21'h800;
   localparam logic [5:0]  HI_PREFIX  = 6'b110110;

   // default depth of the job queue
   localparam int QUEUE_DEPTH_DEF = 4;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_unit;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_last;
   } rsp_type;

   // one classified unit: optional flushed high surrogate, optional code point
   typedef struct packed {
      logic        first_valid;
      logic [9:0]  first_bits;
      logic        second_valid;
      logic [20:0] second_cp;
      logic        last_unit;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic {
      PH_FLUSH,
      PH_MAIN
   } back_phase_type;

   // number of UTF-8 bytes for a code point
   function automatic logic [2:0] enc_len(input logic [20:0] cp);
      logic [2:0] len;
      if (cp < LIM_ONE) begin
         len = 3'd1;
      end else if (cp < LIM_TWO) begin
         len = 3'd2;
      end else if (cp < SUPP_BASE) begin
         len = 3'd3;
      end else begin
         len = 3'd4;
      end
      return len;
   endfunction

   // byte number idx (first byte is zero) of the UTF-8 form of cp
   function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      if (cp < LIM_ONE) begin
         b = {1'b0, cp[6:0]};
      end else if (cp < LIM_TWO) begin
         case (idx)
            2'd0:    b = {3'b110, cp[10:6]};
            default: b = {2'b10, cp[5:0]};
         endcase
      end else if (cp < SUPP_BASE) begin
         case (idx)
            2'd0:    b = {4'b1110, cp[15:12]};
            2'd1:    b = {2'b10, cp[11:6]};
            default: b = {2'b10, cp[5:0]};
         endcase
      end else begin
         case (idx)
            2'd0:    b = {5'b11110, cp[20:18]};
            2'd1:    b = {2'b10, cp[17:12]};
            2'd2:    b = {2'b10, cp[11:6]};
            default: b = {2'b10, cp[5:0]};
         endcase
      end
      return b;
   endfunction

endpackage

`default_nettype wire

[rtl/core/utf16_to_utf8_encoder.sv]
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder: UTF-16 code units in, UTF-8 byte beats out.
// Accepted units are queued as jobs; bytes leave via the output register.
// One byte per cycle unless rsp_stall holds it; a unit yields 0 to 6 bytes.
// Reset clears the held surrogate, the job queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf16_to_utf8_encoder_macros.svh"

module utf16_to_utf8_encoder #(
   parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire u16u8_pkg::req_type req_payload,
   output logic                    req_stall,
   output logic                    rsp_valid,
   output u16u8_pkg::rsp_type      rsp_payload,
   input  wire logic               rsp_stall
);

   u16u8_pkg::q_status_type q_status;
   u16u8_pkg::job_type      push_job;
   u16u8_pkg::job_type      head_job;
   logic                    q_push;
   logic                    q_pop;
   logic                    str_end;

   // front: classify units and pair surrogates
   u16u8_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   // job queue
   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // back: serialize UTF-8 bytes
   u16u8_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .q_status    (q_status),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

   // final byte of a string on the output
   assign str_end = rsp_valid && rsp_payload.string_last;

   // checks
   `U16U8_ASSERT_IMP(a_no_push_full, clock, reset, q_status.full, !q_push)
   `U16U8_ASSERT_IMP(a_no_pop_empty, clock, reset, q_pop, !q_status.empty)
   `U16U8_ASSERT_IMP(a_str_end_run_end, clock, reset, str_end, rsp_payload.run_last)
   `U16U8_ASSERT_NXT(a_pop_gives_beat, clock, reset, q_pop, rsp_valid && rsp_payload.run_last)

endmodule

`default_nettype wire

[rtl/core/u16u8_front.sv]
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates and pushes encode jobs to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire u16u8_pkg::req_type      req_payload,
   output logic                         req_stall,
   input  wire u16u8_pkg::q_status_type q_status,
   output logic                         q_push,
   output u16u8_pkg::job_type           q_job
);

   logic       held_valid_ff, held_valid_in;
   logic [9:0] held_bits_ff, held_bits_in;
   logic       accept;
   logic       is_high;
   logic       is_low;
   logic       hold_new;
   logic [20:0] pair_cp;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   // classify the incoming unit
   always_comb begin
      is_high  = req_payload.code_unit inside {[u16u8_pkg::HI_FIRST:u16u8_pkg::HI_LAST]};
      is_low   = req_payload.code_unit inside {[u16u8_pkg::LO_FIRST:u16u8_pkg::LO_LAST]};
      hold_new = is_high && !req_payload.last_unit;
      pair_cp  = u16u8_pkg::SUPP_BASE
               + {1'b0, held_bits_ff, req_payload.code_unit[9:0]};
   end

   // build the job; a held surrogate that meets a low one becomes a pair
   always_comb begin
      q_job.first_valid  = held_valid_ff && !is_low;
      q_job.first_bits   = held_bits_ff;
      q_job.second_valid = !hold_new;
      q_job.second_cp    = (held_valid_ff && is_low) ? pair_cp
                                                     : {5'b0, req_payload.code_unit};
      q_job.last_unit    = req_payload.last_unit;
      q_push             = accept && (held_valid_ff || !hold_new);
   end

   // held surrogate state
   always_comb begin
      held_valid_in = held_valid_ff;
      held_bits_in  = held_bits_ff;
      if (accept) begin
         held_valid_in = hold_new;
         if (hold_new) begin
            held_bits_in = req_payload.code_unit[9:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
      end
      held_bits_ff <= held_bits_in;
   end

endmodule

`default_nettype wire

[rtl/core/u16u8_queue.sv]
// ----------------------------------------------------------------------------
// u16u8_queue
// Small job queue between the front and back; head is read in place.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_queue #(
   parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire u16u8_pkg::job_type   push_job,
   input  wire logic                 pop,
   output u16u8_pkg::job_type        head_job,
   output u16u8_pkg::q_status_type   status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   u16u8_pkg::job_type job_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      logic [AW-1:0] n;
      n = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
      return n;
   endfunction

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_job     = job_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         job_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[rtl/core/u16u8_back.sv]
// ----------------------------------------------------------------------------
// u16u8_back
// Walks the head job byte by byte into a registered output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire u16u8_pkg::job_type      head_job,
   input  wire u16u8_pkg::q_status_type q_status,
   output logic                         q_pop,
   output logic                         rsp_valid,
   output u16u8_pkg::rsp_type           rsp_payload,
   input  wire logic                    rsp_stall
);

   u16u8_pkg::back_phase_type phase_ff, phase_in;
   logic [1:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   u16u8_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   logic        out_load;
   logic        emit;
   logic        cur_main;
   logic [20:0] cur_cp;
   logic [2:0]  cur_len;
   logic        part_end;
   logic        job_end;

   // current code point and byte position
   always_comb begin
      cur_main = (phase_ff == u16u8_pkg::PH_MAIN) || !head_job.first_valid;
      cur_cp   = cur_main ? head_job.second_cp
                          : {5'b0, u16u8_pkg::HI_PREFIX, head_job.first_bits};
      cur_len  = u16u8_pkg::enc_len(cur_cp);
      part_end = ({1'b0, idx_ff} + 3'd1) == cur_len;
      job_end  = part_end && (cur_main || !head_job.second_valid);
      out_load = !rsp_valid_ff || !rsp_stall;
      emit     = out_load && !q_status.empty;
      q_pop    = emit && job_end;
   end

   // sequencer: flush part then main part
   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      if (emit) begin
         if (job_end) begin
            phase_in = u16u8_pkg::PH_FLUSH;
            idx_in   = 2'd0;
         end else if (part_end) begin
            phase_in = u16u8_pkg::PH_MAIN;
            idx_in   = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   // output beat register
   always_comb begin
      rsp_valid_in   = out_load ? !q_status.empty : rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (emit) begin
         rsp_payload_in.out_byte    = u16u8_pkg::enc_byte(cur_cp, idx_ff);
         rsp_payload_in.run_last    = job_end;
         rsp_payload_in.string_last = job_end && head_job.last_unit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= u16u8_pkg::PH_FLUSH;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

[verif/utf16_to_utf8_encoder_test.sv]
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_test
// Drives UTF-16 code unit beats into the encoder and checks every UTF-8 byte
// beat, in order, against a behavioral transcoder kept in step with the
// accepted input. Covers range edges, surrogate pairs, lone and flushed
// surrogates, random strings, random idling on both sides and back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_to_utf8_encoder_test;

   localparam int HOLD_CYCLES    = 150;
   localparam int TAIL_CYCLES    = 20;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int PHASE_UNITS    = 28;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   u16u8_pkg::req_type req_payload = '0;
   logic               req_stall;
   logic               rsp_valid;
   u16u8_pkg::rsp_type rsp_payload;
   logic               rsp_stall = 1'b0;

   // beats waiting for the driver, bytes waiting for the dut
   u16u8_pkg::req_type units_pending[$];
   u16u8_pkg::rsp_type utf8_expect[$];
   u16u8_pkg::rsp_type unit_bytes[$];

   // transcoder state: a high surrogate waiting for its partner
   logic       surr_held = 1'b0;
   logic [9:0] surr_bits = '0;

   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   logic hold_off      = 1'b0;
   int   units_queued  = 0;
   int   fail_count    = 0;

   utf16_to_utf8_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      fail_count++;
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
   endtask

   // append the UTF-8 form of one code point to unit_bytes
   function automatic void encode_point(input logic [20:0] cp);
      u16u8_pkg::rsp_type b;
      b = '0;
      if (cp < 21'h80) begin
         b.out_byte = {1'b0, cp[6:0]};
         unit_bytes.push_back(b);
      end else if (cp < 21'h800) begin
         b.out_byte = {3'b110, cp[10:6]};
         unit_bytes.push_back(b);
         b.out_byte = {2'b10, cp[5:0]};
         unit_bytes.push_back(b);
      end else if (cp < 21'h10000) begin
         b.out_byte = {4'b1110, cp[15:12]};
         unit_bytes.push_back(b);
         b.out_byte = {2'b10, cp[11:6]};
         unit_bytes.push_back(b);
         b.out_byte = {2'b10, cp[5:0]};
         unit_bytes.push_back(b);
      end else begin
         b.out_byte = {5'b11110, cp[20:18]};
         unit_bytes.push_back(b);
         b.out_byte = {2'b10, cp[17:12]};
         unit_bytes.push_back(b);
         b.out_byte = {2'b10, cp[11:6]};
         unit_bytes.push_back(b);
         b.out_byte = {2'b10, cp[5:0]};
         unit_bytes.push_back(b);
      end
   endfunction

   // work out the bytes one accepted code unit releases
   task automatic predict_utf8(input u16u8_pkg::req_type beat);
      logic               is_high;
      logic               is_low;
      logic               paired;
      logic [20:0]        cp;
      u16u8_pkg::rsp_type b;
      unit_bytes.delete();
      is_high = beat.code_unit >= u16u8_pkg::HI_FIRST && beat.code_unit <= u16u8_pkg::HI_LAST;
      is_low  = beat.code_unit >= u16u8_pkg::LO_FIRST && beat.code_unit <= u16u8_pkg::LO_LAST;
      paired  = 1'b0;
      if (surr_held) begin
         surr_held = 1'b0;
         if (is_low) begin
            cp = 21'h10000 + {1'b0, surr_bits, 10'b0} + {11'b0, beat.code_unit[9:0]};
            encode_point(cp);
            paired = 1'b1;
         end else begin
            encode_point({5'b0, u16u8_pkg::HI_FIRST | {6'b0, surr_bits}});
         end
      end
      if (!paired) begin
         if (is_high && !beat.last_unit) begin
            surr_held = 1'b1;
            surr_bits = beat.code_unit[9:0];
         end else begin
            encode_point({5'b0, beat.code_unit});
         end
      end
      // flags go on the final byte of this unit
      for (int i = 0; i < unit_bytes.size(); i++) begin
         b = unit_bytes[i];
         if (i == unit_bytes.size() - 1) begin
            b.run_last    = 1'b1;
            b.string_last = beat.last_unit;
         end
         utf8_expect.push_back(b);
      end
   endtask

   // driver: offer the next pending beat, hold a stalled one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_utf8(req_payload);
         end
         if (!req_valid || !req_stall) begin
            if (units_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= units_pending.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each accepted byte beat with the oldest expected one
   always @(posedge clock) begin : monitor
      u16u8_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (utf8_expect.size() == 0) begin
               report_mismatch("byte with none expected", int'(rsp_payload.out_byte), 0);
            end else begin
               want = utf8_expect.pop_front();
               if (rsp_payload.out_byte !== want.out_byte)
                  report_mismatch("out_byte", int'(rsp_payload.out_byte),
                                  int'(want.out_byte));
               if (rsp_payload.run_last !== want.run_last)
                  report_mismatch("run_last", int'(rsp_payload.run_last),
                                  int'(want.run_last));
               if (rsp_payload.string_last !== want.string_last)
                  report_mismatch("string_last", int'(rsp_payload.string_last),
                                  int'(want.string_last));
            end
         end
         rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
      end
   end

   task automatic push_unit(input logic [15:0] cu, input logic fin);
      u16u8_pkg::req_type beat;
      beat.code_unit = cu;
      beat.last_unit = fin;
      units_pending.push_back(beat);
      units_queued++;
   endtask

   // one random string, mostly well formed, with some surrogate noise
   task automatic queue_string(input int max_units);
      logic [15:0] units[$];
      int          len;
      len = $urandom_range(max_units, 1);
      while (units.size() < len) begin
         case ($urandom_range(9))
            0: units.push_back(16'($urandom_range(16'h7F)));
            1: units.push_back(16'($urandom_range(16'h7FF, 16'h80)));
            2: units.push_back(16'($urandom_range(16'hD7FF, 16'h800)));
            3: units.push_back(16'($urandom_range(16'hFFFF, 16'hE000)));
            4, 5: begin
               units.push_back(16'(u16u8_pkg::HI_FIRST + $urandom_range(10'h3FF)));
               units.push_back(16'(u16u8_pkg::LO_FIRST + $urandom_range(10'h3FF)));
            end
            6: units.push_back(16'(u16u8_pkg::HI_FIRST + $urandom_range(10'h3FF)));
            7: units.push_back(16'(u16u8_pkg::LO_FIRST + $urandom_range(10'h3FF)));
            8: units.push_back(16'($urandom_range(16'hFFFF)));
            default: begin
               case ($urandom_range(3))
                  0: units.push_back(16'h0000);
                  1: units.push_back(16'hFFFF);
                  2: units.push_back(u16u8_pkg::HI_LAST);
                  default: units.push_back(u16u8_pkg::LO_LAST);
               endcase
            end
         endcase
      end
      for (int i = 0; i < units.size(); i++) begin
         push_unit(units[i], i == units.size() - 1);
      end
   endtask

   task automatic wait_drained();
      while (units_pending.size() != 0 || req_valid || utf8_expect.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin : stimulus
      int start;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // range edges of one, two and three byte forms
      push_unit(16'h0000, 1'b0);
      push_unit(16'h007F, 1'b0);
      push_unit(16'h0080, 1'b0);
      push_unit(16'h07FF, 1'b0);
      push_unit(16'h0800, 1'b0);
      push_unit(16'hD7FF, 1'b0);
      push_unit(16'hE000, 1'b0);
      push_unit(16'hFFFF, 1'b1);
      // surrogate pairs at both corners
      push_unit(u16u8_pkg::HI_FIRST, 1'b0);
      push_unit(u16u8_pkg::LO_FIRST, 1'b0);
      push_unit(u16u8_pkg::HI_LAST, 1'b0);
      push_unit(u16u8_pkg::LO_LAST, 1'b1);
      // lone low surrogates
      push_unit(u16u8_pkg::LO_FIRST, 1'b0);
      push_unit(u16u8_pkg::LO_LAST, 1'b1);
      // held high flushed by a plain unit, by another high, by a 2-byte and a 3-byte unit
      push_unit(u16u8_pkg::HI_FIRST, 1'b0);
      push_unit(16'h0041, 1'b0);
      push_unit(16'hD801, 1'b0);
      push_unit(u16u8_pkg::HI_LAST, 1'b0);
      push_unit(16'h07FF, 1'b0);
      push_unit(16'hD812, 1'b0);
      push_unit(16'hFFFF, 1'b1);
      // high surrogate on the final unit, after a held one and alone
      push_unit(16'hDBFE, 1'b0);
      push_unit(u16u8_pkg::HI_FIRST, 1'b1);
      push_unit(16'hDAAA, 1'b1);
      wait_drained();

      // receiver holds off while the sender keeps offering
      fork
         begin
            hold_off = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off = 1'b0;
         end
         begin
            start = units_queued;
            while (units_queued - start < 24) queue_string(6);
         end
      join
      // sender pauses until every byte is out
      wait_drained();

      // random strings under each idling mix
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 75; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 75; end
            default: begin send_idle_pct = 21; stall_pct = 21; end
         endcase
         start = units_queued;
         while (units_queued - start < PHASE_UNITS) queue_string(8);
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (utf8_expect.size() != 0) begin
         report_mismatch("bytes never seen", 0, utf8_expect.size());
      end
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // run limit
   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
